@@ src/srw_pkg.sv @@
// Shared types and constants for the sequence retransmit window.
// Used by srw_ctrl and seq_retransmit_window; depends on nothing.
package srw_pkg;

  // Default sizes handed to the top-level parameters
  localparam int DEF_WINDOW_DEPTH = 64;
  localparam int DEF_HANDLE_BITS  = 16;

  localparam int ID_W      = 32;
  localparam int HANDLE_W  = 16;
  localparam int FUNC_W    = 3;
  localparam int STATUS_W  = 2;
  localparam int PENDING_W = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INIT_SEND_ID = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_RECV_ID = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RECOVERY_EN  = 2'd2;

  // Operation codes carried in func
  typedef enum logic [FUNC_W-1:0] {
    FN_SEND    = 3'd0,
    FN_ACK     = 3'd1,
    FN_RECV    = 3'd2,
    FN_RESEND  = 3'd3,
    FN_RESTART = 3'd4
  } srw_func_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_OLD  = 2'd1,
    ST_FULL = 2'd2,
    ST_OFF  = 2'd3
  } srw_status_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_ACK_CHK,
    S_RS_OUT,
    S_EMIT
  } srw_state_t;

  // Input beat
  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [ID_W-1:0]     seq_id;
    logic [HANDLE_W-1:0] payload_handle;
  } srw_in_t;

  // Result beat
  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [ID_W-1:0]      out_seq_id;
    logic [HANDLE_W-1:0]  out_handle;
    logic                 entry_valid;
    logic [ID_W-1:0]      next_expected_rx;
    logic [PENDING_W-1:0] pending_count;
    logic                 last;
  } srw_out_t;

  // Configuration register contents
  typedef struct packed {
    logic [ID_W-1:0] init_send_id;
    logic [ID_W-1:0] init_recv_id;
    logic            recovery_enable;
  } srw_cfg_t;

endpackage

@@ src/srw_ring_mem.sv @@
// Ring storage for unacknowledged entries: one write port, one read port,
// registered read data. Depends on nothing.
module srw_ring_mem #(
  parameter int DEPTH  = 64,
  parameter int DATA_W = 48,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  // Write one entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Read one entry; hold the data while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ src/srw_ctrl.sv @@
// Sequencer for the retransmit window: counters, ack and resend walks over
// the ring memory, and the result register. Depends on srw_pkg.
module srw_ctrl #(
  parameter int WINDOW_DEPTH = srw_pkg::DEF_WINDOW_DEPTH,
  parameter int HANDLE_BITS  = srw_pkg::DEF_HANDLE_BITS,
  parameter int PTR_W        = $clog2(WINDOW_DEPTH),
  parameter int CNT_W        = $clog2(WINDOW_DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  srw_pkg::srw_cfg_t             cfg,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  srw_pkg::srw_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output srw_pkg::srw_out_t             out_data,
  output logic                          mem_wr_en,
  output logic [PTR_W-1:0]              mem_wr_addr,
  output logic [srw_pkg::ID_W-1:0]      mem_wr_id,
  output logic [HANDLE_BITS-1:0]        mem_wr_handle,
  output logic                          mem_rd_en,
  output logic [PTR_W-1:0]              mem_rd_addr,
  input  logic [srw_pkg::ID_W-1:0]      mem_rd_id,
  input  logic [HANDLE_BITS-1:0]        mem_rd_handle
);

  localparam int SUM_W = CNT_W + 1;
  localparam int EXT_W = srw_pkg::HANDLE_W + 32;

  // Ring position base + off, wrapped at the window depth
  function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(WINDOW_DEPTH)) begin
      sum = sum - SUM_W'(WINDOW_DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  // Wrapping compare: a lies before b
  function automatic logic id_older(input logic [srw_pkg::ID_W-1:0] a,
                                    input logic [srw_pkg::ID_W-1:0] b);
    logic [srw_pkg::ID_W-1:0] diff;
    diff = a - b;
    return diff[srw_pkg::ID_W-1];
  endfunction

  srw_pkg::srw_state_t          state_r, state_nxt;
  srw_pkg::srw_in_t             cmd_r, cmd_nxt;
  logic [srw_pkg::ID_W-1:0]     send_next_r, send_next_nxt;
  logic [srw_pkg::ID_W-1:0]     recv_next_r, recv_next_nxt;
  logic [PTR_W-1:0]             head_r, head_nxt;
  logic [CNT_W-1:0]             fill_r, fill_nxt;
  logic [CNT_W-1:0]             idx_r, idx_nxt;
  srw_pkg::srw_status_t         res_status_r, res_status_nxt;
  logic [srw_pkg::ID_W-1:0]     res_id_r, res_id_nxt;
  logic                         out_valid_r, out_valid_nxt;
  srw_pkg::srw_out_t            out_data_r, out_data_nxt;

  srw_pkg::srw_func_t           func_e;
  logic                         out_free;
  logic                         walk_ack;
  logic                         walk_rs;
  logic                         ack_older;
  logic                         ack_done;
  logic                         rs_last;
  logic [CNT_W-1:0]             idx_inc;
  logic                         load;
  logic                         load_entry;
  logic [EXT_W-1:0]             in_handle_ext;
  logic [EXT_W-1:0]             rd_handle_ext;

  // Shared decode of the held command and the walk conditions
  assign func_e     = srw_pkg::srw_func_t'(cmd_r.func);
  assign out_free   = !out_valid_r || !out_stall;
  assign walk_ack   = (func_e == srw_pkg::FN_ACK) && cfg.recovery_enable &&
                      (fill_r != '0);
  assign walk_rs    = (func_e == srw_pkg::FN_RESEND) && cfg.recovery_enable &&
                      (fill_r != '0);
  assign ack_older  = id_older(mem_rd_id, cmd_r.seq_id);
  assign ack_done   = !ack_older || (fill_r == CNT_W'(1));
  assign idx_inc    = idx_r + CNT_W'(1);
  assign rs_last    = (idx_inc == fill_r);

  // Fit handles to the stored width and back to the port width
  assign in_handle_ext = EXT_W'(cmd_r.payload_handle);
  assign rd_handle_ext = {{(EXT_W - HANDLE_BITS){1'b0}}, mem_rd_handle};

  assign in_stall = (state_r != srw_pkg::S_IDLE);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      srw_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = srw_pkg::S_EXEC;
        end
      end
      srw_pkg::S_EXEC: begin
        if (walk_ack) begin
          state_nxt = srw_pkg::S_ACK_CHK;
        end else if (walk_rs) begin
          state_nxt = srw_pkg::S_RS_OUT;
        end else begin
          state_nxt = out_free ? srw_pkg::S_IDLE : srw_pkg::S_EMIT;
        end
      end
      srw_pkg::S_ACK_CHK: begin
        if (ack_done) begin
          state_nxt = out_free ? srw_pkg::S_IDLE : srw_pkg::S_EMIT;
        end
      end
      srw_pkg::S_RS_OUT: begin
        if (out_free && rs_last) begin
          state_nxt = srw_pkg::S_IDLE;
        end
      end
      srw_pkg::S_EMIT: begin
        if (out_free) begin
          state_nxt = srw_pkg::S_IDLE;
        end
      end
      default: state_nxt = srw_pkg::S_IDLE;
    endcase
  end

  // Datapath, memory controls and result loading
  always_comb begin
    cmd_nxt        = cmd_r;
    send_next_nxt  = send_next_r;
    recv_next_nxt  = recv_next_r;
    head_nxt       = head_r;
    fill_nxt       = fill_r;
    idx_nxt        = idx_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    mem_wr_en      = 1'b0;
    mem_wr_addr    = ring_add(head_r, fill_r);
    mem_wr_id      = send_next_r;
    mem_wr_handle  = in_handle_ext[HANDLE_BITS-1:0];
    mem_rd_en      = 1'b0;
    mem_rd_addr    = head_r;
    load           = 1'b0;
    load_entry     = 1'b0;

    case (state_r)
      srw_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd_nxt = in_data;
        end
      end
      srw_pkg::S_EXEC: begin
        res_status_nxt = srw_pkg::ST_OK;
        res_id_nxt     = '0;
        case (func_e)
          srw_pkg::FN_SEND: begin
            if (!cfg.recovery_enable) begin
              res_status_nxt = srw_pkg::ST_OFF;
            end else if (fill_r == CNT_W'(WINDOW_DEPTH)) begin
              res_status_nxt = srw_pkg::ST_FULL;
            end else begin
              mem_wr_en     = 1'b1;
              fill_nxt      = fill_r + CNT_W'(1);
              send_next_nxt = send_next_r + srw_pkg::ID_W'(1);
              res_id_nxt    = send_next_r;
            end
          end
          srw_pkg::FN_ACK: begin
            if (!cfg.recovery_enable) begin
              res_status_nxt = srw_pkg::ST_OFF;
            end else if (walk_ack) begin
              mem_rd_en = 1'b1;
            end
          end
          srw_pkg::FN_RECV: begin
            if (cfg.recovery_enable) begin
              if (id_older(cmd_r.seq_id, recv_next_r)) begin
                res_status_nxt = srw_pkg::ST_OLD;
              end else begin
                recv_next_nxt = cmd_r.seq_id + srw_pkg::ID_W'(1);
              end
            end
          end
          srw_pkg::FN_RESEND: begin
            if (!cfg.recovery_enable) begin
              res_status_nxt = srw_pkg::ST_OFF;
            end else if (walk_rs) begin
              mem_rd_en = 1'b1;
              idx_nxt   = '0;
            end
          end
          srw_pkg::FN_RESTART: begin
            send_next_nxt = cfg.init_send_id;
            recv_next_nxt = cfg.init_recv_id;
            head_nxt      = '0;
            fill_nxt      = '0;
          end
          default: begin
            res_status_nxt = srw_pkg::ST_OK;
          end
        endcase
        load = !walk_ack && !walk_rs && out_free;
      end
      srw_pkg::S_ACK_CHK: begin
        // Pop the head while it is older than the ack, one entry a cycle
        res_status_nxt = srw_pkg::ST_OK;
        res_id_nxt     = '0;
        if (ack_older) begin
          head_nxt = ring_add(head_r, CNT_W'(1));
          fill_nxt = fill_r - CNT_W'(1);
        end
        if (ack_done) begin
          load = out_free;
        end else begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = head_nxt;
        end
      end
      srw_pkg::S_RS_OUT: begin
        // Emit one stored entry a cycle while the output is free, fetch the next behind it
        if (out_free) begin
          load       = 1'b1;
          load_entry = 1'b1;
          if (!rs_last) begin
            idx_nxt     = idx_inc;
            mem_rd_en   = 1'b1;
            mem_rd_addr = ring_add(head_r, idx_inc);
          end
        end
      end
      srw_pkg::S_EMIT: begin
        load = out_free;
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  // Assemble the result beat from post-step state
  always_comb begin
    out_data_nxt.status           = load_entry ? srw_pkg::ST_OK : res_status_nxt;
    out_data_nxt.out_seq_id       = load_entry ? mem_rd_id : res_id_nxt;
    out_data_nxt.out_handle       = load_entry ? rd_handle_ext[srw_pkg::HANDLE_W-1:0]
                                               : '0;
    out_data_nxt.entry_valid      = load_entry;
    out_data_nxt.next_expected_rx = recv_next_nxt;
    out_data_nxt.pending_count    = srw_pkg::PENDING_W'(fill_nxt);
    out_data_nxt.last             = load_entry ? rs_last : 1'b1;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  // Control state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= srw_pkg::S_IDLE;
      send_next_r <= '0;
      recv_next_r <= '0;
      head_r      <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      send_next_r <= send_next_nxt;
      recv_next_r <= recv_next_nxt;
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    idx_r        <= idx_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    if (load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ src/seq_retransmit_window.sv @@
// Top level: config registers, srw_ctrl sequencer and srw_ring_mem; uses srw_pkg.
// The result is registered. An ack checks the head entries one by one and a resend emits
// every held entry in turn, one ring read each; a new command is taken only once the
// sequencer is back in idle.
// Reset: synchronous; counters and ring pointers clear at once, no memory sweep.
module seq_retransmit_window #(
  parameter int WINDOW_DEPTH = srw_pkg::DEF_WINDOW_DEPTH,
  parameter int HANDLE_BITS  = srw_pkg::DEF_HANDLE_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [srw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [srw_pkg::CFG_DAT_W-1:0]     cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  srw_pkg::srw_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output srw_pkg::srw_out_t                 out_data
);

  localparam int PTR_W  = $clog2(WINDOW_DEPTH);
  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int DATA_W = srw_pkg::ID_W + HANDLE_BITS;

  srw_pkg::srw_cfg_t              cfg_r, cfg_nxt;
  logic                           mem_wr_en;
  logic [PTR_W-1:0]               mem_wr_addr;
  logic [srw_pkg::ID_W-1:0]       mem_wr_id;
  logic [HANDLE_BITS-1:0]         mem_wr_handle;
  logic                           mem_rd_en;
  logic [PTR_W-1:0]               mem_rd_addr;
  logic [DATA_W-1:0]              mem_rd_data;

  // Decode register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        srw_pkg::REG_INIT_SEND_ID: cfg_nxt.init_send_id    = cfg_wdata;
        srw_pkg::REG_INIT_RECV_ID: cfg_nxt.init_recv_id    = cfg_wdata;
        srw_pkg::REG_RECOVERY_EN:  cfg_nxt.recovery_enable = cfg_wdata[0];
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  // Hold configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.init_send_id    <= '0;
      cfg_r.init_recv_id    <= '0;
      cfg_r.recovery_enable <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  srw_ctrl #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .HANDLE_BITS  (HANDLE_BITS),
    .PTR_W        (PTR_W),
    .CNT_W        (CNT_W)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .mem_wr_en     (mem_wr_en),
    .mem_wr_addr   (mem_wr_addr),
    .mem_wr_id     (mem_wr_id),
    .mem_wr_handle (mem_wr_handle),
    .mem_rd_en     (mem_rd_en),
    .mem_rd_addr   (mem_rd_addr),
    .mem_rd_id     (mem_rd_data[DATA_W-1:HANDLE_BITS]),
    .mem_rd_handle (mem_rd_data[HANDLE_BITS-1:0])
  );

  // Reads and writes of one entry never fall in the same cycle: the walks
  // only read, and a send writes in a cycle of its own.
  srw_ring_mem #(
    .DEPTH  (WINDOW_DEPTH),
    .DATA_W (DATA_W),
    .ADDR_W (PTR_W)
  ) u_ring (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data ({mem_wr_id, mem_wr_handle}),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

endmodule
